>>> design/rcup_pkg.sv
// rcup_pkg: shared constants, result type and raw-to-pulse conversion
// for the RC channel unpacker. No dependencies.
`default_nettype none

package rcup_pkg;

  // Channel value geometry
  localparam int unsigned RAW_BITS   = 11;
  localparam int unsigned BYTE_BITS  = 8;
  // Bits held between bytes never exceed RAW_BITS - 1
  localparam int unsigned HOLD_BITS  = RAW_BITS - 1;
  localparam int unsigned HOLD_CNT_W = 4;
  localparam int unsigned ACC_W      = HOLD_BITS + BYTE_BITS;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned PULSE_W    = 12;

  localparam logic [RAW_BITS-1:0]   RawMask     = 11'h7FF;
  localparam logic signed [11:0]    RawCenter   = 12'sd992;
  localparam logic signed [13:0]    PulseCenter = 14'sd1500;

  // One decoded channel
  typedef struct packed {
    logic                  last_channel;
    logic [PULSE_W-1:0]    pulse_us;
    logic [RAW_BITS-1:0]   raw_value;
    logic [IDX_W-1:0]      channel_index;
  } rcup_result_t;

  // (raw - 992) * 5 / 8 + 1500, division truncating toward zero
  function automatic logic [PULSE_W-1:0] raw_to_pulse(input logic [RAW_BITS-1:0] raw);
    logic signed [11:0] diff;
    logic signed [13:0] prod;
    logic signed [13:0] quot;
    diff = $signed({1'b0, raw}) - RawCenter;
    prod = (14'(diff) <<< 2) + 14'(diff);
    // bias negative values so the shift rounds toward zero
    if (prod[13]) begin
      quot = (prod + 14'sd7) >>> 3;
    end else begin
      quot = prod >>> 3;
    end
    return PULSE_W'(quot + PulseCenter);
  endfunction

endpackage

`default_nettype wire

>>> design/rcup_unpacker.sv
// rcup_unpacker: bit accumulator, bit count and channel count, plus the
// per-byte unpack step. Depends on rcup_pkg.
`default_nettype none

module rcup_unpacker #(
  parameter int unsigned CHANNEL_COUNT = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   take_i,
  input  wire logic [7:0]             payload_byte_i,
  input  wire logic                   frame_first_i,
  output logic                        emit_o,
  output rcup_pkg::rcup_result_t      result_o
);
  import rcup_pkg::*;

  localparam int unsigned CNT_W = $clog2(CHANNEL_COUNT + 1);

  logic [HOLD_BITS-1:0]  acc_q, acc_d;
  logic [HOLD_CNT_W-1:0] held_q, held_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic [HOLD_BITS-1:0]  acc_base;
  logic [HOLD_CNT_W-1:0] held_base;
  logic [CNT_W-1:0]      cnt_base;
  logic [ACC_W-1:0]      acc_new;
  logic [HOLD_CNT_W:0]   held_sum;
  logic                  frame_done;
  logic [CNT_W+IDX_W-1:0] cnt_ext;
  logic [RAW_BITS-1:0]   raw;

  // First byte of a frame starts from a cleared state
  always_comb begin
    acc_base  = frame_first_i ? '0 : acc_q;
    held_base = frame_first_i ? '0 : held_q;
    cnt_base  = frame_first_i ? '0 : cnt_q;
  end

  // Append byte above the held bits
  assign acc_new    = ACC_W'(acc_base) | (ACC_W'(payload_byte_i) << held_base);
  assign held_sum   = (HOLD_CNT_W + 1)'(held_base) + (HOLD_CNT_W + 1)'(BYTE_BITS);
  assign frame_done = (cnt_base >= CNT_W'(CHANNEL_COUNT));
  assign emit_o     = !frame_done && (held_sum >= (HOLD_CNT_W + 1)'(RAW_BITS));
  assign raw        = acc_new[RAW_BITS-1:0] & RawMask;
  assign cnt_ext    = (CNT_W + IDX_W)'(cnt_base);

  // Result word
  always_comb begin
    result_o.channel_index = cnt_ext[IDX_W-1:0];
    result_o.raw_value     = raw;
    result_o.pulse_us      = raw_to_pulse(raw);
    result_o.last_channel  = (cnt_base == CNT_W'(CHANNEL_COUNT - 1));
  end

  // Next state
  always_comb begin
    if (frame_done) begin
      acc_d  = acc_base;
      held_d = held_base;
      cnt_d  = cnt_base;
    end else if (emit_o) begin
      acc_d  = HOLD_BITS'(acc_new >> RAW_BITS);
      held_d = HOLD_CNT_W'(held_sum - (HOLD_CNT_W + 1)'(RAW_BITS));
      cnt_d  = cnt_base + CNT_W'(1);
    end else begin
      acc_d  = HOLD_BITS'(acc_new);
      held_d = HOLD_CNT_W'(held_sum);
      cnt_d  = cnt_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
      cnt_q  <= '0;
    end else if (take_i) begin
      acc_q  <= acc_d;
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> design/rc_channel_unpack_to_pulse_core.sv
// rc_channel_unpack_to_pulse_core: top level of the RC channel unpacker.
// Depends on rcup_pkg and rcup_unpacker.
//
//  Channel | Dir | tdata (low bit up)                          | tuser       | tlast
//  s_axis  | in  | payload_byte[7:0]                           | frame_first | -
//  m_axis  | out | channel_index[2:0] raw_value[13:3]          | -           | last_channel
//          |     | pulse_us[25:14], zero pad [31:26]           |             |
//
// One byte per cycle sustained while the output is not stalled; a byte passes
// the input register, then the result register after the unpack step.
// A byte that completes no channel only updates the bit accumulator and bit count.
// Reset clears both valid flags and the accumulator, bit and channel counts.
// Output stall holds the result register; the input register keeps taking
// bytes until it is full and cannot advance.
`default_nettype none

module rc_channel_unpack_to_pulse_core #(
  parameter int unsigned CHANNEL_COUNT = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // payload_byte[7:0]
  input  wire logic        s_axis_tuser,  // frame_first
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // channel_index, raw_value, pulse_us, pad
  output logic             m_axis_tlast   // last_channel
);
  import rcup_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_first_q;
  logic         out_valid_q;
  rcup_result_t out_q;

  logic         advance;
  logic         emit;
  rcup_result_t result;

  // Input word moves on when the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
    end
  end

  rcup_unpacker #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_unpacker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (advance),
    .payload_byte_i(in_byte_q),
    .frame_first_i (in_first_q),
    .emit_o        (emit),
    .result_o      (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.pulse_us, out_q.raw_value, out_q.channel_index};
  assign m_axis_tlast  = out_q.last_channel;

endmodule

`default_nettype wire

>>> tb/rcup_checker.sv
// rcup_checker: watches both streams of the RC channel unpacker, predicts each
// channel word from the accepted payload bytes and compares. Depends on rcup_pkg.

module rcup_checker #(
  parameter int unsigned CHANNEL_COUNT = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // payload_byte[7:0]
  input  wire logic        s_axis_tuser,   // frame_first
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,   // channel_index[2:0], raw_value[13:3],
                                           // pulse_us[25:14], zero pad[31:26]
  input  wire logic        m_axis_tlast,   // last_channel
  output int               mismatch_cnt_o,
  output int               pending_o,
  output int               words_seen_o
);
  import rcup_pkg::*;

  localparam int RawMid     = 992;
  localparam int PulseMid   = 1500;
  localparam int MaxReports = 10;

  // predictor state, cleared while reset is held
  logic [17:0]  acc_bits;
  int unsigned  acc_fill;
  int unsigned  chan_cnt;
  rcup_result_t chan_expect_q[$];
  rcup_result_t want_w;
  rcup_result_t got_w;

  // (raw - 992) * 5 / 8 + 1500; int division truncates toward zero
  function automatic logic [PULSE_W-1:0] pulse_width_us(input logic [RAW_BITS-1:0] raw);
    int w;
    w = raw;
    w = (w - RawMid) * 5 / 8 + PulseMid;
    return w[PULSE_W-1:0];
  endfunction

  // Push one payload byte through the unpacker; returns 1 when a channel completes
  function automatic bit unpack_byte(input logic [7:0] b, input logic first,
                                     output rcup_result_t word);
    word = '0;
    if (first) begin
      acc_bits = '0;
      acc_fill = 0;
      chan_cnt = 0;
    end
    // frame already complete: byte is dropped
    if (chan_cnt >= CHANNEL_COUNT) return 1'b0;
    acc_bits = acc_bits | (18'(b) << acc_fill);
    acc_fill += BYTE_BITS;
    if (acc_fill < RAW_BITS) return 1'b0;
    word.channel_index = chan_cnt[IDX_W-1:0];
    word.raw_value     = acc_bits[RAW_BITS-1:0];
    word.pulse_us      = pulse_width_us(acc_bits[RAW_BITS-1:0]);
    word.last_channel  = (chan_cnt + 1 == CHANNEL_COUNT);
    acc_bits = acc_bits >> RAW_BITS;
    acc_fill -= RAW_BITS;
    chan_cnt++;
    return 1'b1;
  endfunction

  // Monitor: compare leaving words, then predict from the accepted byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_bits = '0;
      acc_fill = 0;
      chan_cnt = 0;
      chan_expect_q.delete();
      mismatch_cnt_o = 0;
      words_seen_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_seen_o++;
        got_w = {m_axis_tlast, m_axis_tdata[25:0]};
        if (chan_expect_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= MaxReports)
            $display("%0t: unexpected word: idx %0d raw %0d pulse %0d last %0b",
                     $time, got_w.channel_index, got_w.raw_value, got_w.pulse_us,
                     got_w.last_channel);
        end else begin
          want_w = chan_expect_q.pop_front();
          if (got_w != want_w || m_axis_tdata[31:26] != '0) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= MaxReports) begin
              $write("%0t: word mismatch: exp idx %0d raw %0d pulse %0d last %0b;",
                     $time, want_w.channel_index, want_w.raw_value, want_w.pulse_us,
                     want_w.last_channel);
              $display(" got idx %0d raw %0d pulse %0d last %0b pad %h",
                       got_w.channel_index, got_w.raw_value, got_w.pulse_us,
                       got_w.last_channel, m_axis_tdata[31:26]);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (unpack_byte(s_axis_tdata, s_axis_tuser, want_w))
          chan_expect_q.push_back(want_w);
      end
    end
    pending_o = chan_expect_q.size();
  end

endmodule

>>> tb/tb_rc_channel_unpack_to_pulse_core.sv
// tb_rc_channel_unpack_to_pulse_core: drives payload byte frames into the RC
// channel unpacker and gives the verdict. Depends on rc_channel_unpack_to_pulse_core and rcup_checker.

module tb_rc_channel_unpack_to_pulse_core;

  localparam int unsigned ChannelCount = 8;
  localparam int ClkPeriod     = 4;
  localparam int ResetCycles   = 11;
  localparam int FrameBytes    = (ChannelCount * 11 + 7) / 8;
  localparam int ItemTarget    = 1300;
  localparam int CalmTail      = 200;
  localparam int SqueezeAt     = 400;
  localparam int SqueezeCycles = 64;
  localparam int DrainCycles   = 8;
  localparam int WatchdogTime  = 2_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // payload_byte[7:0]
  logic        s_axis_tuser;   // frame_first
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // channel_index[2:0], raw_value[13:3], pulse_us[25:14], pad
  logic        m_axis_tlast;   // last_channel

  int mismatch_cnt;
  int pending;
  int words_seen;
  int bytes_sent   = 0;
  int frame_starts = 0;

  // idle control shared by sender and receiver
  bit tx_idle_en   = 1'b0;
  bit rx_idle_en   = 1'b0;
  bit squeeze_req  = 1'b0;
  bit squeeze_on   = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  rc_channel_unpack_to_pulse_core #(
    .CHANNEL_COUNT(ChannelCount)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  rcup_checker #(
    .CHANNEL_COUNT(ChannelCount)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending),
    .words_seen_o  (words_seen)
  );

  // mostly random bytes, with the extremes showing up often
  function automatic logic [7:0] rand_payload();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one word, maybe after an idle burst; returns at the falling edge after acceptance
  task automatic put_byte(input logic [7:0] b, input logic first);
    if (tx_idle_en && !squeeze_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (first) frame_starts++;
    @(negedge clk_i);
  endtask

  // Receiver: random stall bursts plus one long hold-off to back up the block
  initial begin : sink
    int hold;
    bit squeeze_done;
    hold = 0;
    squeeze_done = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        squeeze_on   = 1'b1;
        hold = SqueezeCycles - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 16) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        squeeze_on = 1'b0;
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int mode_at;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no first flag after reset, all ones: every channel at full scale
    for (int k = 0; k < FrameBytes; k++) put_byte(8'hFF, 1'b0);
    // frame complete: this byte must give nothing
    put_byte(8'h00, 1'b0);
    // all zeros: every channel at the bottom of the pulse range
    for (int k = 0; k < FrameBytes; k++) put_byte(8'h00, k == 0);
    // restart in the middle of a frame
    put_byte(8'hA5, 1'b1);
    put_byte(8'h5A, 1'b1);

    mode_at = 0;
    while (bytes_sent < ItemTarget) begin
      if (bytes_sent >= ItemTarget - CalmTail) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else if (bytes_sent >= mode_at) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
        mode_at = bytes_sent + 100;
      end
      if (bytes_sent >= SqueezeAt) squeeze_req = 1'b1;

      case ($urandom_range(0, 9))
        0: begin
          // noise: loose bytes with random first flags
          repeat ($urandom_range(1, 4))
            put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        1: begin
          // broken frame, cut short by the next start
          put_byte(rand_payload(), 1'b1);
          repeat ($urandom_range(0, FrameBytes - 2)) put_byte(rand_payload(), 1'b0);
        end
        default: begin
          // well-formed frame, sometimes with trailing bytes past the end
          for (int k = 0; k < FrameBytes; k++) put_byte(rand_payload(), k == 0);
          if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) put_byte(rand_payload(), 1'b0);
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d payload bytes in %0d frame starts, incl. truncated and noisy frames.",
             bytes_sent, frame_starts);
    $display("Compared %0d channel words under random stalls and one long output hold-off.",
             words_seen);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #(WatchdogTime);
    $display("Timeout: %0d channel words still outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
